### hw/rtl/shfr_pkg.sv
// ----------------------------------------------------------------------------
// shfr_pkg: shared types and constants of the sync header frame receiver
// Register map, configuration bundle, queue command and queue status.
// ----------------------------------------------------------------------------
package shfr_pkg;

   localparam int HDR_W       = 64;
   localparam int HLEN_W      = 4;
   localparam int FLEN_W      = 11;
   localparam int BYTE_W      = 8;
   localparam int DATA_W      = 64;
   localparam int ADDR_W      = 5;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      REG_HEADER_BYTES   = 2'd0,
      REG_HEADER_LENGTH  = 2'd1,
      REG_FRAME_LENGTH   = 2'd2,
      REG_RECEIVE_ENABLE = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [HDR_W-1:0]  header_bytes;
      logic [HLEN_W-1:0] header_length;
      logic [FLEN_W-1:0] frame_length;
      logic              receive_enable;
   } cfg_type;

   // One queued unit of output work: a single payload word, or a header replay
   typedef struct packed {
      logic              is_replay;
      logic [BYTE_W-1:0] data;
      logic              last;
      logic [HLEN_W-1:0] count;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [BYTE_W-1:0] header_byte(input logic [HDR_W-1:0] hdr,
                                                     input logic [2:0]       pos);
      header_byte = hdr[{pos, 3'b000} +: BYTE_W];
   endfunction

endpackage

### hw/rtl/shfr_front.sv
// ----------------------------------------------------------------------------
// shfr_front: header match and frame tracking
// Accepts received words, walks the header match, counts frame words and
// queues one command per payload word or per completed header.
// ----------------------------------------------------------------------------
module shfr_front #(
   parameter int MAX_HEADER = 8,
   parameter int MAX_FRAME  = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  shfr_pkg::cfg_type             cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [shfr_pkg::BYTE_W-1:0]   req_rx_byte,
   input  shfr_pkg::queue_status_type    q_status,
   output logic                          push,
   output shfr_pkg::cmd_type             push_cmd
);

   localparam int MW   = (MAX_HEADER > 1) ? $clog2(MAX_HEADER) : 1;
   localparam int HW   = $clog2(MAX_HEADER + 1);
   localparam int FCAP = (MAX_FRAME < 2047) ? MAX_FRAME : 2047;
   localparam int FW   = $clog2(FCAP + 1);

   logic [MW-1:0] matched_ff, matched_in;
   logic          in_payload_ff, in_payload_in;
   logic [FW-1:0] bytes_ff, bytes_in;
   logic [HW-1:0] hl;
   logic [HW-1:0] m1;
   logic [FW-1:0] fl;
   logic [FW-1:0] cnt_next;
   logic          accept;
   logic          mismatch;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   // effective lengths: zero header is one byte, both saturate at their caps
   always_comb begin
      if (cfg.header_length == '0) begin
         hl = HW'(1);
      end else if (32'(cfg.header_length) > MAX_HEADER) begin
         hl = HW'(MAX_HEADER);
      end else begin
         hl = HW'(cfg.header_length);
      end
      if (32'(cfg.frame_length) > FCAP) begin
         fl = FW'(FCAP);
      end else begin
         fl = FW'(cfg.frame_length);
      end
   end

   assign m1       = HW'(matched_ff) + HW'(1);
   assign cnt_next = bytes_ff + FW'(1);
   assign mismatch = (32'(matched_ff) >= 32'(hl)) ||
                     (req_rx_byte != shfr_pkg::header_byte(cfg.header_bytes, 3'(matched_ff)));

   always_comb begin
      matched_in         = matched_ff;
      in_payload_in      = in_payload_ff;
      bytes_in           = bytes_ff;
      push               = 1'b0;
      push_cmd.is_replay = 1'b0;
      push_cmd.data      = req_rx_byte;
      push_cmd.last      = 1'b0;
      push_cmd.count     = shfr_pkg::HLEN_W'(hl);
      if (accept && cfg.receive_enable) begin
         if (in_payload_ff) begin
            push          = 1'b1;
            push_cmd.last = (cnt_next >= fl);
            if (cnt_next >= fl) begin
               in_payload_in = 1'b0;
               bytes_in      = '0;
               matched_in    = '0;
            end else begin
               bytes_in = cnt_next;
            end
         end else if (mismatch) begin
            // drop the partial match and the word
            matched_in    = '0;
            in_payload_in = 1'b0;
            bytes_in      = '0;
         end else if (m1 < hl) begin
            matched_in = MW'(m1);
         end else begin
            push               = 1'b1;
            push_cmd.is_replay = 1'b1;
            push_cmd.last      = (32'(fl) <= 32'(hl));
            matched_in         = '0;
            if (32'(fl) <= 32'(hl)) begin
               in_payload_in = 1'b0;
               bytes_in      = '0;
            end else begin
               in_payload_in = 1'b1;
               bytes_in      = FW'(32'(hl));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matched_ff    <= '0;
         in_payload_ff <= 1'b0;
         bytes_ff      <= '0;
      end else begin
         matched_ff    <= matched_in;
         in_payload_ff <= in_payload_in;
         bytes_ff      <= bytes_in;
      end
   end

   a_payload_no_match: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> (matched_ff == '0))
      else $error("header match count nonzero during payload");

endmodule

### hw/rtl/shfr_queue.sv
// ----------------------------------------------------------------------------
// shfr_queue: command queue between front and back
// Small register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module shfr_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  shfr_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output shfr_pkg::cmd_type          head,
   output shfr_pkg::queue_status_type q_status
);

   localparam int DEPTH = shfr_pkg::QUEUE_DEPTH;
   localparam int QAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   shfr_pkg::cmd_type entries_ff [DEPTH];
   logic [QAW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QAW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   assign q_status.full  = (32'(count_ff) == DEPTH);
   assign q_status.empty = (count_ff == '0);
   assign head           = entries_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + QAW'(1);
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + QAW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !push)
      else $error("push into full command queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty command queue");

endmodule

### hw/rtl/shfr_back.sv
// ----------------------------------------------------------------------------
// shfr_back: result sequencer
// Drains queued commands into the output register, one word per cycle
// unless rsp_ready stalls it; a header replay steps through the header bytes.
// ----------------------------------------------------------------------------
module shfr_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [shfr_pkg::HDR_W-1:0]    header_bytes,
   input  shfr_pkg::queue_status_type    q_status,
   input  shfr_pkg::cmd_type             head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [shfr_pkg::BYTE_W-1:0]   rsp_frame_byte,
   output logic                          rsp_frame_last
);

   logic [2:0]                  idx_ff, idx_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [shfr_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic                        last_ff, last_in;
   logic                        load;
   logic                        final_beat;

   assign load       = !q_status.empty && (!rsp_valid_ff || rsp_ready);
   assign final_beat = !head.is_replay ||
                       (({1'b0, idx_ff} + shfr_pkg::HLEN_W'(1)) == head.count);
   assign pop        = load && final_beat;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      byte_in      = byte_ff;
      last_in      = last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         idx_in       = final_beat ? 3'd0 : idx_ff + 3'd1;
         if (head.is_replay) begin
            byte_in = shfr_pkg::header_byte(header_bytes, idx_ff);
            last_in = final_beat && head.last;
         end else begin
            byte_in = head.data;
            last_in = head.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = byte_ff;
   assign rsp_frame_last = last_ff;

   a_replay_index: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != 3'd0) |-> (!q_status.empty && head.is_replay))
      else $error("replay index active without a replay command at queue head");

endmodule

### hw/rtl/sync_header_frame_receiver.sv
// ----------------------------------------------------------------------------
// sync_header_frame_receiver: fixed-length frame delineator on a byte stream
// One received word is accepted per cycle while the queue is not full. While
// enabled, words are matched against the configured header; on the word that
// completes it, the header is replayed as header-length result words, then
// payload words pass one per cycle unless the output stalls, until the frame
// length is reached, with frame_last on the final word. The front end
// classifies each word in the cycle it is accepted and queues a command in a
// two-entry queue; the back end emits one result word per cycle into an
// output register unless rsp_ready stalls it. A header replay occupies the
// back end for header-length words; input stalls only once the queue fills.
// ----------------------------------------------------------------------------
module sync_header_frame_receiver #(
   parameter int MAX_HEADER = 8,
   parameter int MAX_FRAME  = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [shfr_pkg::BYTE_W-1:0]   req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [shfr_pkg::BYTE_W-1:0]   rsp_frame_byte,
   output logic                          rsp_frame_last,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [shfr_pkg::ADDR_W-1:0]   paddr,
   input  logic [shfr_pkg::DATA_W-1:0]   pwdata,
   output logic [shfr_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);

   logic [shfr_pkg::HDR_W-1:0]  header_bytes_ff;
   logic [shfr_pkg::HLEN_W-1:0] header_length_ff;
   logic [shfr_pkg::FLEN_W-1:0] frame_length_ff;
   logic                        receive_enable_ff;
   logic                        wr_en;
   shfr_pkg::reg_index_type     reg_index;
   shfr_pkg::cfg_type           cfg;
   shfr_pkg::queue_status_type  q_status;
   shfr_pkg::cmd_type           push_cmd;
   shfr_pkg::cmd_type           head;
   logic                        push;
   logic                        pop;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite && pready;
   assign reg_index = shfr_pkg::reg_index_type'(paddr[4:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         header_bytes_ff   <= '0;
         header_length_ff  <= shfr_pkg::HLEN_W'(1);
         frame_length_ff   <= shfr_pkg::FLEN_W'(1);
         receive_enable_ff <= 1'b0;
      end else if (wr_en) begin
         case (reg_index)
            shfr_pkg::REG_HEADER_BYTES: begin
               header_bytes_ff <= pwdata;
            end
            shfr_pkg::REG_HEADER_LENGTH: begin
               header_length_ff <= pwdata[shfr_pkg::HLEN_W-1:0];
            end
            shfr_pkg::REG_FRAME_LENGTH: begin
               frame_length_ff <= pwdata[shfr_pkg::FLEN_W-1:0];
            end
            shfr_pkg::REG_RECEIVE_ENABLE: begin
               receive_enable_ff <= pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         shfr_pkg::REG_HEADER_BYTES:   prdata = header_bytes_ff;
         shfr_pkg::REG_HEADER_LENGTH:  prdata = shfr_pkg::DATA_W'(header_length_ff);
         shfr_pkg::REG_FRAME_LENGTH:   prdata = shfr_pkg::DATA_W'(frame_length_ff);
         shfr_pkg::REG_RECEIVE_ENABLE: prdata = shfr_pkg::DATA_W'(receive_enable_ff);
         default:                      prdata = '0;
      endcase
   end

   assign cfg.header_bytes   = header_bytes_ff;
   assign cfg.header_length  = header_length_ff;
   assign cfg.frame_length   = frame_length_ff;
   assign cfg.receive_enable = receive_enable_ff;

   shfr_front #(
      .MAX_HEADER (MAX_HEADER),
      .MAX_FRAME  (MAX_FRAME)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_status    (q_status),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   shfr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   shfr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .header_bytes   (header_bytes_ff),
      .q_status       (q_status),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule
